@@ sv/vwpf_pkg.sv @@
// ----------------------------------------------------------------------------
// vwpf_pkg: shared types and constants
// Opcodes, source codes, fixed widths and the divider request type.
// ----------------------------------------------------------------------------
package vwpf_pkg;

    localparam int DEF_MAX_SAMPLES = 256;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int SUM_W  = 40;
    localparam int MEAN_W = 32;
    localparam int POS_W  = 32;
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 40;
    localparam int ITER_W = 7;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_FUSE  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] SRC_TRI  = 2'd0;
    localparam logic [1:0] SRC_FP   = 2'd1;
    localparam logic [1:0] SRC_DR   = 2'd2;
    localparam logic [1:0] SRC_NONE = 2'd3;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] n_bits;
    } div_req_t;

endpackage

@@ sv/vwpf_div.sv @@
// ----------------------------------------------------------------------------
// vwpf_div: shared restoring divider
// One quotient bit per cycle over the top n_bits of a left-aligned dividend.
// ----------------------------------------------------------------------------
module vwpf_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vwpf_pkg::div_req_t             req,
    input  logic [vwpf_pkg::DVD_W-1:0]     dividend,
    input  logic [vwpf_pkg::DVS_W-1:0]     divisor,
    output logic                           done,
    output logic [vwpf_pkg::DVD_W-1:0]     quotient
);
    import vwpf_pkg::*;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    partial;
    logic [DVS_W+1:0]  diff;
    logic              fits;

    assign partial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, dvs_reg};
    assign fits    = !diff[DVS_W+1];

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = req.n_bits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (req.start) begin
            dvs_reg <= divisor;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without running");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_busy_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !done_reg)
        else $error("divider done while still busy");

endmodule

@@ sv/variance_weighted_position_fusion_unit.sv @@
// ----------------------------------------------------------------------------
// variance_weighted_position_fusion_unit: three-source position fusion
// Accumulates variance samples, holds estimates, fuses on request.
//
//  channel | dir | tdata                          | tuser
//  s_      | in  | variance_value, pos_x, pos_y   | opcode, source, use_third
//  m_      | out | fused_x, fused_y               | fuse_error
//
// Add and store items are applied in the idle state. A fuse item runs the
// shared divider for the mean of each source, checks that the denominator is
// nonzero, runs the divider again for the weight of each source, then
// multiplies, accumulates x and y and loads the result; s_tready is low meanwhile.
// An empty sample list skips the divider and goes to the done state with an error.
// Synchronous active-low reset clears sums, counts, estimates and control.
// A finished fuse holds, with s_tready low, until the previous result leaves.
// ----------------------------------------------------------------------------
module variance_weighted_position_fusion_unit #(
    parameter int MAX_SAMPLES = vwpf_pkg::DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = vwpf_pkg::DEF_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // variance_value, pos_x, pos_y
    input  logic [4:0]  s_tuser,   // opcode, source, use_third
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // fused_x, fused_y
    output logic        m_tuser    // fuse_error
);
    import vwpf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int W_W    = FRAC_BITS + 1;
    localparam int PROD_W = W_W + 1 + POS_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int DEN_W  = MEAN_W + 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_WGT  = 3'd2;
    localparam logic [2:0] ST_MAC  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [1:0]  in_opcode, in_source;
    logic        in_third;
    logic [31:0] in_var;
    logic [POS_W-1:0] in_x, in_y;
    logic        s_acc;

    assign in_opcode = s_tuser[1:0];
    assign in_source = s_tuser[3:2];
    assign in_third  = s_tuser[4];
    assign in_var    = s_tdata[31:0];
    assign in_x      = s_tdata[63:32];
    assign in_y      = s_tdata[95:64];

    logic [SUM_W-1:0]        sum_reg [3];
    logic [CNT_W-1:0]        cnt_reg [3];
    logic signed [POS_W-1:0] est_x_reg [3];
    logic signed [POS_W-1:0] est_y_reg [3];
    logic [MEAN_W-1:0]       mean_reg [3];
    logic [W_W-1:0]          w_reg [3];

    logic [2:0] state_reg;
    logic [2:0] idx_reg;
    logic       third_reg;
    logic       err_reg;
    logic       start_reg;
    logic       wgt_kick_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_err_reg;

    div_req_t          dreq;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic              ddone;
    logic [DVD_W-1:0]  dquo;

    logic [1:0]  mac_src;
    logic        mac_y;
    logic [DEN_W-1:0] den, num;
    logic [SUM_W:0]   sum_add;
    logic [MEAN_W-1:0] mean_q;
    logic signed [ACC_W-1:0] shx, shy;
    logic signed [POS_W-1:0] satx, saty;
    logic [1:0]  isrc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign isrc     = idx_reg[1:0];

    always_comb begin
        if (third_reg) begin
            den = {(DEN_W-1)'(mean_reg[0]) + (DEN_W-1)'(mean_reg[1])
                   + (DEN_W-1)'(mean_reg[2]), 1'b0};
            case (isrc)
                SRC_TRI: num = DEN_W'(mean_reg[1]) + DEN_W'(mean_reg[0]);
                SRC_FP:  num = DEN_W'(mean_reg[2]) + DEN_W'(mean_reg[0]);
                default: num = DEN_W'(mean_reg[1]) + DEN_W'(mean_reg[2]);
            endcase
        end else begin
            den = DEN_W'(mean_reg[0]) + DEN_W'(mean_reg[1]);
            num = (isrc == SRC_TRI) ? DEN_W'(mean_reg[0]) : DEN_W'(mean_reg[1]);
        end
    end

    always_comb begin
        dreq.start = start_reg;
        if (state_reg == ST_MEAN) begin
            dreq.n_bits = ITER_W'(SUM_W);
            dvd = {sum_reg[isrc], {(DVD_W-SUM_W){1'b0}}};
            dvs = DVS_W'(cnt_reg[isrc]);
        end else begin
            dreq.n_bits = ITER_W'(DEN_W + FRAC_BITS);
            dvd = {num, {(DVD_W-DEN_W){1'b0}}};
            dvs = DVS_W'(den);
        end
    end

    vwpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (ddone),
        .quotient (dquo)
    );

    assign mean_q = (dquo[DVD_W-1:MEAN_W] != '0) ? '1 : dquo[MEAN_W-1:0];

    always_comb begin
        case (idx_reg)
            3'd0, 3'd3: mac_src = SRC_TRI;
            3'd1, 3'd4: mac_src = SRC_FP;
            default:    mac_src = SRC_DR;
        endcase
        mac_y = (idx_reg >= 3'd3);
    end

    assign sum_add = {1'b0, sum_reg[in_source]} + (SUM_W+1)'(in_var);
    assign shx = accx_reg >>> FRAC_BITS;
    assign shy = accy_reg >>> FRAC_BITS;

    always_comb begin
        if (shx > ACC_W'(64'sd2147483647))        satx = 32'sh7fffffff;
        else if (shx < ACC_W'(-64'sd2147483648))  satx = 32'sh80000000;
        else                                      satx = shx[POS_W-1:0];
        if (shy > ACC_W'(64'sd2147483647))        saty = 32'sh7fffffff;
        else if (shy < ACC_W'(-64'sd2147483648))  saty = 32'sh80000000;
        else                                      saty = shy[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
                est_x_reg[i] <= '0;
                est_y_reg[i] <= '0;
            end
        end else begin
            if (start_reg) begin
                start_reg <= 1'b0;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (in_opcode)
                            OP_ADD: begin
                                if (in_source != SRC_NONE
                                        && cnt_reg[in_source] < CNT_W'(MAX_SAMPLES)) begin
                                    sum_reg[in_source] <= sum_add[SUM_W] ? '1
                                                          : sum_add[SUM_W-1:0];
                                    cnt_reg[in_source] <= cnt_reg[in_source] + CNT_W'(1);
                                end
                            end
                            OP_STORE: begin
                                if (in_source != SRC_NONE) begin
                                    est_x_reg[in_source] <= in_x;
                                    est_y_reg[in_source] <= in_y;
                                end
                            end
                            OP_FUSE: begin
                                third_reg <= in_third;
                                idx_reg   <= '0;
                                w_reg[2]  <= '0;
                                if (cnt_reg[SRC_TRI] == '0 || cnt_reg[SRC_FP] == '0
                                        || (in_third && cnt_reg[SRC_DR] == '0)) begin
                                    err_reg   <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else begin
                                    err_reg   <= 1'b0;
                                    start_reg <= 1'b1;
                                    state_reg <= ST_MEAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MEAN: begin
                    if (ddone) begin
                        mean_reg[isrc] <= mean_q;
                        if (idx_reg == 3'd2 || (idx_reg == 3'd1 && !third_reg)) begin
                            idx_reg   <= '0;
                            state_reg <= ST_WGT;
                        end else begin
                            idx_reg   <= idx_reg + 3'd1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_WGT: begin
                    if (idx_reg == '0 && !start_reg && den == '0) begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end else if (idx_reg == '0 && wgt_kick_reg) begin
                        start_reg <= 1'b1;
                    end else if (ddone) begin
                        w_reg[isrc] <= dquo[W_W-1:0];
                        if (idx_reg == 3'd2 || (idx_reg == 3'd1 && !third_reg)) begin
                            idx_reg   <= '0;
                            accx_reg  <= '0;
                            accy_reg  <= '0;
                            state_reg <= ST_MAC;
                        end else begin
                            idx_reg   <= idx_reg + 3'd1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_MAC: begin
                    prod_reg <= $signed({1'b0, w_reg[mac_src]})
                                * (mac_y ? est_y_reg[mac_src] : est_x_reg[mac_src]);
                    if (idx_reg != '0) begin
                        if (idx_reg >= 3'd4) begin
                            accy_reg <= accy_reg + ACC_W'(prod_reg);
                        end else begin
                            accx_reg <= accx_reg + ACC_W'(prod_reg);
                        end
                    end
                    if (idx_reg == 3'd6) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_err_reg   <= err_reg;
                        m_data_reg  <= err_reg ? 64'd0 : {saty, satx};
                        for (int i = 0; i < 3; i++) begin
                            sum_reg[i] <= '0;
                            cnt_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // start the first weight division once the denominator is known nonzero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_kick_reg <= 1'b0;
        end else begin
            wgt_kick_reg <= (state_reg == ST_MEAN) && ddone
                            && (idx_reg == 3'd2 || (idx_reg == 3'd1 && !third_reg));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

    a_fuse_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_opcode == OP_FUSE) |=> state_reg != ST_IDLE)
        else $error("fuse item did not start a run");

    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ddone |-> (state_reg == ST_MEAN || state_reg == ST_WGT))
        else $error("divider result outside a division phase");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done phase");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CNT_W'(MAX_SAMPLES) && cnt_reg[1] <= CNT_W'(MAX_SAMPLES)
        && cnt_reg[2] <= CNT_W'(MAX_SAMPLES))
        else $error("sample count past its limit");

endmodule

@@ bench/variance_weighted_position_fusion_unit_tb.sv @@
// ----------------------------------------------------------------------------
// variance_weighted_position_fusion_unit_tb: self-checking bench
// Drives add, store and fuse items with random gaps on both sides, predicts
// each fused position from a bit-accurate model and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variance_weighted_position_fusion_unit_tb;
    import vwpf_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               err;
    } fused_pos_t;

    class fusion_scoreboard;
        localparam int SAMPLE_LIMIT = 256;
        localparam int FRAC         = 16;

        logic [39:0]        var_sum [3];
        int                 n_samples [3];
        logic signed [31:0] est_x [3];
        logic signed [31:0] est_y [3];
        fused_pos_t         pending_fusions [$];
        int                 fail_count;
        int                 fuse_count;
        int                 error_count;

        function new();
            for (int i = 0; i < 3; i++) begin
                var_sum[i]   = '0;
                n_samples[i] = 0;
                est_x[i]     = '0;
                est_y[i]     = '0;
            end
            fail_count  = 0;
            fuse_count  = 0;
            error_count = 0;
        endfunction

        function longint unsigned mean_var(int s);
            longint unsigned m;
            m = longint'(var_sum[s]) / n_samples[s];
            return (m > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : m;
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void note_item(logic [1:0] op, logic [1:0] src, logic [31:0] var_in,
                                logic signed [31:0] x, logic signed [31:0] y,
                                logic third);
            longint unsigned t, f, d, den;
            longint unsigned w [3];
            longint          ax, ay;
            logic [40:0]     s;
            fused_pos_t      r;
            bit              err;
            case (op)
                OP_ADD: begin
                    if (src < 3 && n_samples[src] < SAMPLE_LIMIT) begin
                        s = {1'b0, var_sum[src]} + var_in;
                        var_sum[src] = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
                        n_samples[src]++;
                    end
                end
                OP_STORE: begin
                    if (src < 3) begin
                        est_x[src] = x;
                        est_y[src] = y;
                    end
                end
                OP_FUSE: begin
                    err = 0;
                    w = '{0, 0, 0};
                    for (int i = 0; i < (third ? 3 : 2); i++)
                        if (n_samples[i] == 0) err = 1;
                    if (!err) begin
                        t = mean_var(0);
                        f = mean_var(1);
                        if (third) begin
                            d = mean_var(2);
                            den = 2 * (t + f + d);
                            if (den == 0) err = 1;
                            else begin
                                w[0] = ((f + t) << FRAC) / den;
                                w[1] = ((d + t) << FRAC) / den;
                                w[2] = ((f + d) << FRAC) / den;
                            end
                        end else begin
                            den = t + f;
                            if (den == 0) err = 1;
                            else begin
                                w[0] = (t << FRAC) / den;
                                w[1] = (f << FRAC) / den;
                            end
                        end
                    end
                    if (err) begin
                        r.x = '0;
                        r.y = '0;
                        r.err = 1;
                        error_count++;
                    end else begin
                        ax = 0;
                        ay = 0;
                        for (int i = 0; i < 3; i++) begin
                            ax += longint'(w[i]) * longint'(est_x[i]);
                            ay += longint'(w[i]) * longint'(est_y[i]);
                        end
                        r.x = sat32(ax >>> FRAC);
                        r.y = sat32(ay >>> FRAC);
                        r.err = 0;
                    end
                    pending_fusions = {pending_fusions, r};
                    fuse_count++;
                    for (int i = 0; i < 3; i++) begin
                        var_sum[i]   = '0;
                        n_samples[i] = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic err);
            fused_pos_t e;
            if (pending_fusions.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h err=%b", $time, x, y, err);
                fail_count++;
                return;
            end
            e = pending_fusions.pop_front();
            if (x !== e.x) begin
                $display("%0t: fused_x expected %h actual %h", $time, e.x, x);
                fail_count++;
            end
            if (y !== e.y) begin
                $display("%0t: fused_y expected %h actual %h", $time, e.y, y);
                fail_count++;
            end
            if (err !== e.err) begin
                $display("%0t: fuse_error expected %b actual %b", $time, e.err, err);
                fail_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    fusion_scoreboard fusion_sb;
    int  items_sent;
    int  idle_cycles;
    bit  steady_flow;

    variance_weighted_position_fusion_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                fusion_sb.note_item(s_tuser[1:0], s_tuser[3:2], s_tdata[31:0],
                                    s_tdata[63:32], s_tdata[95:64], s_tuser[4]);
            if (m_tvalid && m_tready)
                fusion_sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** variance_weighted_position_fusion_unit: FAILED **");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (pick_gap() == 0);
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) steady_flow <= ~steady_flow;
    end

    task automatic send_item(logic [1:0] op, logic [1:0] src, logic [31:0] var_in,
                             logic [31:0] x, logic [31:0] y, logic third);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x, var_in};
        s_tuser  <= {third, src, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (!(op == OP_NONE || (op != OP_FUSE && src == SRC_NONE))) items_sent++;
    endtask

    task automatic add_sample(logic [1:0] src, logic [31:0] v);
        send_item(OP_ADD, src, v, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic store_pos(logic [1:0] src, logic [31:0] x, logic [31:0] y);
        send_item(OP_STORE, src, $urandom, x, y, 1'($urandom_range(0, 1)));
    endtask

    task automatic fuse(logic third);
        send_item(OP_FUSE, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, third);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (fusion_sb.pending_fusions.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    initial begin
        int n;
        logic [31:0] v;
        fusion_sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        steady_flow = 0;
        items_sent  = 0;
        idle_cycles = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty lists, zero variance, extremes, ignored codes
        fuse(1'b0);
        fuse(1'b1);
        add_sample(SRC_TRI, 32'h0);
        add_sample(SRC_FP, 32'h0);
        add_sample(SRC_DR, 32'h0);
        fuse(1'b1);
        store_pos(SRC_TRI, 32'h7FFF_FFFF, 32'h8000_0000);
        store_pos(SRC_FP, 32'h8000_0000, 32'h7FFF_FFFF);
        store_pos(SRC_DR, 32'hFFFF_FFFF, 32'h0000_0001);
        store_pos(SRC_NONE, 32'h1234_5678, 32'h1234_5678);
        add_sample(SRC_TRI, 32'hFFFF_FFFF);
        add_sample(SRC_FP, 32'h0000_0001);
        add_sample(SRC_DR, 32'h8000_0000);
        add_sample(SRC_NONE, 32'h1000_0000);
        send_item(OP_NONE, SRC_TRI, 32'h5, 32'h5, 32'h5, 1'b1);
        fuse(1'b1);
        add_sample(SRC_TRI, 32'hFFFF_FFFF);
        add_sample(SRC_FP, 32'hFFFF_FFFF);
        fuse(1'b0);
        add_sample(SRC_TRI, 32'h0001_0000);
        fuse(1'b0);
        drain();

        // full sample list: the 257th add is dropped
        for (int i = 0; i < 257; i++) add_sample(SRC_TRI, 32'hFFFF_FFFF - i);
        add_sample(SRC_FP, 32'h0000_0003);
        fuse(1'b0);

        while (items_sent < 1650) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    send_item(OP_NONE, 2'($urandom), $urandom, $urandom, $urandom,
                              1'($urandom));
                else
                    send_item(2'($urandom_range(0, 1)), SRC_NONE, $urandom, $urandom,
                              $urandom, 1'($urandom));
            end else begin
                for (int s = 0; s < 3; s++) begin
                    if ($urandom_range(0, 2) == 0)
                        store_pos(s[1:0], $urandom, $urandom);
                    n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
                    for (int k = 0; k < n; k++) begin
                        v = ($urandom_range(0, 29) == 0) ? 32'h0 : rand_var();
                        add_sample(s[1:0], v);
                    end
                end
                fuse(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) == 0) drain();
        end
        drain();
        repeat (300) @(posedge aclk);

        $display("Run covered %0d items and %0d fuse results, %0d of them errors.",
                 items_sent, fusion_sb.fuse_count, fusion_sb.error_count);
        if (fusion_sb.fail_count == 0 && fusion_sb.pending_fusions.size() == 0)
            $display("** variance_weighted_position_fusion_unit: PASSED **");
        else
            $display("** variance_weighted_position_fusion_unit: FAILED **");
        $finish;
    end
endmodule

@@ variance_weighted_position_fusion_unit.f @@
sv/vwpf_pkg.sv
sv/vwpf_div.sv
sv/variance_weighted_position_fusion_unit.sv
bench/variance_weighted_position_fusion_unit_tb.sv
